@@ hdl/rag_pkg.sv @@
// Shared types and constants for the range-add / global-argmin block.
// No dependencies; used by rag_cell, the top level and the checker.
`default_nettype none

package rag_pkg;

    localparam int unsigned IDX_W       = 3;
    localparam int unsigned VAL_W       = 64;
    localparam int unsigned S_TDATA_W   = 72;
    localparam int unsigned M_TDATA_W   = 72;

    localparam logic [VAL_W-1:0] SLOT_RESET_VALUE = 64'd1000000009;

    // Token handed from one cell to the next: the update and the running min.
    typedef struct packed {
        logic             valid;
        logic             has_best;
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
        logic [VAL_W-1:0] amt;
        logic [VAL_W-1:0] best;
        logic [IDX_W-1:0] best_idx;
    } token_t;

endpackage

`default_nettype wire

@@ hdl/rag_cell.sv @@
// One slot cell: holds a slot value, applies the passing range add and
// folds its value into the running minimum. Depends on rag_pkg.
`default_nettype none

module rag_cell #(
    parameter int unsigned CELL_INDEX = 0
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            advance,
    input  wire rag_pkg::token_t tok_in,
    output rag_pkg::token_t      tok_out
);

    localparam logic [rag_pkg::IDX_W-1:0] CELL_TAG = rag_pkg::IDX_W'(CELL_INDEX);

    logic [rag_pkg::VAL_W-1:0] slot_reg;
    logic [rag_pkg::VAL_W-1:0] slot_next;
    rag_pkg::token_t           tok_reg;
    rag_pkg::token_t           tok_next;
    logic                      in_range;
    logic                      take;

    always_comb begin
        in_range  = (CELL_INDEX >= int'(tok_in.lo)) && (CELL_INDEX <= int'(tok_in.hi));
        slot_next = in_range ? (slot_reg + tok_in.amt) : slot_reg;
        // strict less keeps the lower index on ties
        take      = !tok_in.has_best || ($signed(slot_next) < $signed(tok_in.best));

        tok_next          = tok_in;
        tok_next.has_best = 1'b1;
        tok_next.best     = take ? slot_next : tok_in.best;
        tok_next.best_idx = take ? CELL_TAG : tok_in.best_idx;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg      <= rag_pkg::SLOT_RESET_VALUE;
            tok_reg.valid <= 1'b0;
        end else if (advance) begin
            tok_reg <= tok_next;
            if (tok_in.valid) begin
                slot_reg <= slot_next;
            end
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

@@ hdl/range_add_global_argmin_top.sv @@
// A token walks the cell chain, one cell per cycle while the chain advances,
// adding and comparing; the result beat is taken from the last cell's register.
// Throughput: one beat per cycle while m_tready is high; the whole chain
// stalls while a result beat waits in the last cell's register.
// Reset: every slot loads 1000000009 at once, no clearing pass.
// Top level of the range-add / global-argmin chain; uses rag_pkg, rag_cell.
`default_nettype none

module range_add_global_argmin_top #(
    parameter int unsigned SLOT_COUNT = 8
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output      logic                            s_tready,
    // [2:0] range_low, [5:3] range_high, [69:6] amount, [71:70] zero
    input  wire logic [rag_pkg::S_TDATA_W-1:0]   s_tdata,
    output      logic                            m_tvalid,
    input  wire logic                            m_tready,
    // [63:0] min_value, [66:64] min_index, [71:67] zero
    output      logic [rag_pkg::M_TDATA_W-1:0]   m_tdata
);

    rag_pkg::token_t chain [SLOT_COUNT+1];
    rag_pkg::token_t head_tok;
    rag_pkg::token_t last_tok;
    logic            advance;

    assign last_tok = chain[SLOT_COUNT];
    assign advance  = !last_tok.valid || m_tready;
    assign s_tready = advance;

    always_comb begin
        head_tok          = '0;
        head_tok.valid    = s_tvalid;
        head_tok.has_best = 1'b0;
        head_tok.lo       = s_tdata[2:0];
        head_tok.hi       = s_tdata[5:3];
        head_tok.amt      = s_tdata[69:6];
    end

    assign chain[0] = head_tok;

    for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
        rag_cell #(
            .CELL_INDEX(i)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .advance (advance),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
    end

    assign m_tvalid = last_tok.valid;
    assign m_tdata  = {5'b0, last_tok.best_idx, last_tok.best};

endmodule

`default_nettype wire

@@ hdl/rag_checker.sv @@
// Port-level checker for range_add_global_argmin_top, bound to it below.
// Depends on rag_pkg.
`default_nettype none

module rag_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [rag_pkg::S_TDATA_W-1:0] s_tdata,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [rag_pkg::M_TDATA_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat valid right after reset");

    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready disagrees with chain stall");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("input beat changed while waiting");

endmodule

bind range_add_global_argmin_top rag_checker u_rag_checker (.*);

`default_nettype wire

@@ verif/range_add_global_argmin_top_tb.sv @@
// Self-checking testbench for range_add_global_argmin_top: drives range-add beats and
// checks every min/argmin beat against an in-bench slot model, with random stalls.
// Depends on rag_pkg and range_add_global_argmin_top.

module range_add_global_argmin_top_tb;

    localparam int unsigned SLOT_COUNT = 8;
    localparam logic [rag_pkg::VAL_W-1:0] VAL_MAX = 64'h7fff_ffff_ffff_ffff;
    localparam logic [rag_pkg::VAL_W-1:0] VAL_MIN = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [rag_pkg::VAL_W-1:0] min_value;
        logic [rag_pkg::IDX_W-1:0] min_index;
    } argmin_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [rag_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [rag_pkg::M_TDATA_W-1:0] m_tdata;

    logic [rag_pkg::VAL_W-1:0] slot_model [SLOT_COUNT];
    argmin_t                   pending_argmin_q [$];

    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    int hold_left  = 0;
    int rx_stall_left = 0;

    int mismatch_count  = 0;
    int updates_sent    = 0;
    int results_checked = 0;
    int empty_ranges    = 0;
    int wrapped_sums    = 0;

    always #4 aclk = ~aclk;

    range_add_global_argmin_top #(
        .SLOT_COUNT(SLOT_COUNT)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // adds amt to slots lo..hi of the model, returns the new min and its lowest index
    function automatic argmin_t apply_range_add(logic [rag_pkg::IDX_W-1:0] lo,
                                                logic [rag_pkg::IDX_W-1:0] hi,
                                                logic [rag_pkg::VAL_W-1:0] amt);
        argmin_t                   best;
        logic [rag_pkg::VAL_W-1:0] sum;
        if (lo > hi)
            empty_ranges++;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (i >= lo && i <= hi) begin
                sum = slot_model[i] + amt;
                if (slot_model[i][rag_pkg::VAL_W-1] == amt[rag_pkg::VAL_W-1] &&
                    sum[rag_pkg::VAL_W-1] != amt[rag_pkg::VAL_W-1])
                    wrapped_sums++;
                slot_model[i] = sum;
            end
        end
        best.min_value = slot_model[0];
        best.min_index = '0;
        for (int i = 1; i < SLOT_COUNT; i++) begin
            if ($signed(slot_model[i]) < $signed(best.min_value)) begin
                best.min_value = slot_model[i];
                best.min_index = rag_pkg::IDX_W'(i);
            end
        end
        return best;
    endfunction

    // mostly short, now and then long
    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 9)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [rag_pkg::VAL_W-1:0] rand_amount();
        longint v;
        case ($urandom_range(0, 5))
            0: v = longint'($urandom_range(0, 14)) - 7;
            1: v = longint'($urandom_range(0, 2000000000)) - 1000000000;
            2: begin
                case ($urandom_range(0, 3))
                    0: v = VAL_MAX;
                    1: v = VAL_MIN;
                    2: v = 0;
                    default: v = -1;
                endcase
            end
            3: begin
                v = longint'(1) << $urandom_range(0, 63);
                if ($urandom_range(0, 1))
                    v = -v;
            end
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    task automatic report_mismatch(string what, logic [rag_pkg::VAL_W-1:0] got,
                                   logic [rag_pkg::VAL_W-1:0] want);
        $display("MISMATCH %s: got %0h want %0h (result beat %0d)", what, got, want,
                 results_checked);
        mismatch_count++;
    endtask

    task automatic send_update(logic [rag_pkg::IDX_W-1:0] lo, logic [rag_pkg::IDX_W-1:0] hi,
                               logic [rag_pkg::VAL_W-1:0] amt);
        int      gap;
        argmin_t next_want;
        gap = (tx_idle_en && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, amt, hi, lo};
        do @(posedge aclk); while (!s_tready);
        next_want = apply_range_add(lo, hi, amt);
        pending_argmin_q = {pending_argmin_q, next_want};
        updates_sent++;
    endtask

    task automatic send_random_update();
        logic [rag_pkg::IDX_W-1:0] a, b;
        a = rag_pkg::IDX_W'($urandom_range(0, 7));
        b = rag_pkg::IDX_W'($urandom_range(0, 7));
        if ($urandom_range(0, 3) == 0 || a <= b)
            send_update(a, b, rand_amount());
        else
            send_update(b, a, rand_amount());
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_argmin_q.size() != 0)
            @(posedge aclk);
    endtask

    task automatic test_directed_cases();
        send_update(3'd0, 3'd0, 64'd0);            // all tied at reset value
        send_update(3'd7, 3'd7, -64'sd1);          // top slot alone
        send_update(3'd0, 3'd7, VAL_MIN);
        send_update(3'd0, 3'd7, VAL_MAX);
        send_update(3'd5, 3'd2, -64'sd5000000000); // empty range
        send_update(3'd7, 3'd0, VAL_MIN);          // empty range
        send_update(3'd3, 3'd3, VAL_MAX);          // wraps negative
        send_update(3'd3, 3'd3, VAL_MAX);
        send_update(3'd2, 3'd2, VAL_MIN - slot_model[2]);
        send_update(3'd5, 3'd5, VAL_MIN - slot_model[5]); // tie, lower index wins
        send_update(3'd0, 3'd0, VAL_MIN - slot_model[0]);
        send_update(3'd0, 3'd7, -64'sd1);          // tied minima wrap to max
        send_update(3'd1, 3'd6, 64'd1);
        send_update(3'd6, 3'd6, 64'd0);
        send_update(3'd0, 3'd7, VAL_MAX);
        send_update(3'd4, 3'd4, VAL_MIN);
        send_update(3'd7, 3'd7, VAL_MIN - slot_model[7]);
        send_update(3'd4, 3'd4, VAL_MIN - slot_model[4]);
        send_update(3'd0, 3'd7, 64'd0);
    endtask

    task automatic test_random_updates(int count);
        repeat (count) send_random_update();
    endtask

    task automatic test_back_to_back(int count);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (count) send_random_update();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    task automatic test_output_hold(int count);
        tx_idle_en = 1'b0;
        hold_left  = 300;
        repeat (count) send_random_update();
        tx_idle_en = 1'b1;
    endtask

    task automatic test_drain_pause(int count);
        repeat (count) send_random_update();
        drain_results();
        repeat (count) send_random_update();
    endtask

    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (rx_stall_left > 0) begin
            m_tready <= 1'b0;
            rx_stall_left--;
        end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
            m_tready <= 1'b0;
            rx_stall_left = pick_gap() - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_beat
        argmin_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_argmin_q.size() == 0) begin
                report_mismatch("result beat with nothing pending", m_tdata[63:0], '0);
            end else begin
                want = pending_argmin_q.pop_front();
                if (m_tdata[63:0] !== want.min_value)
                    report_mismatch("min_value", m_tdata[63:0], want.min_value);
                if (m_tdata[66:64] !== want.min_index)
                    report_mismatch("min_index", rag_pkg::VAL_W'(m_tdata[66:64]),
                                    rag_pkg::VAL_W'(want.min_index));
            end
            results_checked++;
        end
    end

    initial begin
        for (int i = 0; i < SLOT_COUNT; i++)
            slot_model[i] = rag_pkg::SLOT_RESET_VALUE;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_random_updates(700);
        test_back_to_back(150);
        test_output_hold(40);
        test_drain_pause(20);
        test_random_updates(150);

        drain_results();
        repeat (4 * SLOT_COUNT) @(posedge aclk);
        if (pending_argmin_q.size() != 0)
            report_mismatch("results never delivered",
                            rag_pkg::VAL_W'(pending_argmin_q.size()), '0);

        $display("Summary: %0d range updates (%0d empty ranges, %0d wrapped slot sums)",
                 updates_sent, empty_ranges, wrapped_sums);
        $display("Summary: %0d beats checked; ties, long back-pressure and an idle drain run",
                 results_checked);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("Timeout with %0d results still pending", pending_argmin_q.size());
        $display("Verification failed");
        $finish;
    end

endmodule
